@@ rtl/dcmf_pkg.sv @@
// shared types and constants of the dark channel minimum filter
`default_nettype none
package dcmf_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxRadius = 7;
  localparam int StoreRows = 2 * MaxRadius + 1;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = 12;
  localparam int SlotW     = $clog2(StoreRows);
  localparam int CfgW      = 12;

  localparam logic [SlotW-1:0] SlotLast = SlotW'(StoreRows - 1);
  localparam logic [7:0]       PixMax   = 8'd255;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic       action;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_t;

  typedef struct packed {
    logic [7:0] dark_value;
    logic       run_last;
    logic       frame_last;
  } out_t;

  // column request travelling down the cell chain
  typedef struct packed {
    logic            vld;
    logic            last;
    logic [ColW-1:0] addr;
    logic [7:0]      minv;
  } link_t;

  // line store write
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic [ColW-1:0]  addr;
    logic [7:0]       data;
  } wr_t;

endpackage
`default_nettype wire

@@ rtl/dcmf_cell.sv @@
// one line store row with its stage of the column minimum chain
`default_nettype none
module dcmf_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire logic [dcmf_pkg::ColW-1:0] wr_addr_i,
  input  wire logic [7:0]     wr_data_i,
  input  wire logic           incl_i,
  input  wire dcmf_pkg::link_t link_i,
  output dcmf_pkg::link_t     link_o
);

  logic [7:0] mem_q [dcmf_pkg::MaxWidth];
  logic [7:0] rd_q;
  dcmf_pkg::link_t s1_q;
  dcmf_pkg::link_t s2_q;

  // row memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[link_i.addr];
  end

  // first stage waits on the read, second folds the row value in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q      <= link_i;
      s2_q.vld  <= s1_q.vld;
      s2_q.last <= s1_q.last;
      s2_q.addr <= s1_q.addr;
      s2_q.minv <= (incl_i && (rd_q < s1_q.minv)) ? rd_q : s1_q.minv;
    end
  end

  assign link_o = s2_q;

endmodule
`default_nettype wire

@@ rtl/dcmf_ctrl.sv @@
// registers, frame counters and output sequencing of the filter
`default_nettype none
module dcmf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire dcmf_pkg::in_t      in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dcmf_pkg::out_t          out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [dcmf_pkg::CfgW-1:0] cfg_data_i,
  output dcmf_pkg::wr_t           wr_o,
  output logic [dcmf_pkg::StoreRows-1:0] mask_o,
  output dcmf_pkg::link_t         head_o,
  input  wire dcmf_pkg::link_t    tail_i
);

  localparam int ColW  = dcmf_pkg::ColW;
  localparam int RowW  = dcmf_pkg::RowW;
  localparam int SlotW = dcmf_pkg::SlotW;
  localparam int Rows  = dcmf_pkg::StoreRows;

  dcmf_pkg::ctrl_state_e state_q, state_d;

  logic [10:0]      w_raw_q, w_raw_d;
  logic [RowW-1:0]  h_raw_q, h_raw_d;
  logic [2:0]       r_q, r_d;
  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [3:0]       rem_q, rem_d;
  logic [ColW-1:0]  cur_q, cur_d, chi_q, chi_d;
  logic [Rows-1:0]  mask_q, mask_d;
  logic [7:0]       acc_q, acc_d, res_q, res_d;

  logic [10:0]      eff_w;
  logic [ColW-1:0]  wm1;
  logic [RowW-1:0]  eff_h, hm1;
  logic             in_acc, cfg_acc, out_acc, fin, in_open, row_ok, col_end;
  logic [7:0]       pix_min;
  logic [3:0]       n_out;
  logic [10:0]      c_sum;
  logic [RowW:0]    r_sum;
  logic [RowW-1:0]  lo_row, hi_row;
  logic [2:0]       dr;
  logic [SlotW:0]   lo_tmp, diff;
  logic [SlotW-1:0] lo_slot;
  logic [3:0]       cnt;
  logic [7:0]       fold;

  // effective frame geometry
  always_comb begin
    if (w_raw_q == 11'd0) begin
      eff_w = 11'd1;
    end else if (w_raw_q > 11'(dcmf_pkg::MaxWidth)) begin
      eff_w = 11'(dcmf_pkg::MaxWidth);
    end else begin
      eff_w = w_raw_q;
    end
    eff_h = (h_raw_q == '0) ? RowW'(1) : h_raw_q;
  end
  assign wm1 = ColW'(eff_w - 11'd1);
  assign hm1 = eff_h - RowW'(1);

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign fin     = (out_row_q == hm1) && (out_col_q == wm1);
  assign in_open = in_row_q < eff_h;

  // channel minimum and number of outputs the pixel completes
  always_comb begin
    pix_min = in_data_i.blue;
    if (in_data_i.green < pix_min) pix_min = in_data_i.green;
    if (in_data_i.red < pix_min) pix_min = in_data_i.red;
    row_ok  = in_row_q >= RowW'(r_q);
    col_end = in_col_q == wm1;
    n_out   = 4'd0;
    if (row_ok) begin
      if (!col_end) begin
        n_out = (in_col_q >= ColW'(r_q)) ? 4'd1 : 4'd0;
      end else if (eff_w < 11'({1'b0, r_q} + 4'd1)) begin
        n_out = 4'(eff_w);
      end else begin
        n_out = {1'b0, r_q} + 4'd1;
      end
    end
  end

  // window bounds and row slot mask of the current output
  always_comb begin
    c_sum  = 11'(out_col_q) + 11'(r_q);
    r_sum  = (RowW+1)'(out_row_q) + (RowW+1)'(r_q);
    hi_row = (r_sum > (RowW+1)'(hm1)) ? hm1 : r_sum[RowW-1:0];
    dr     = (out_row_q >= RowW'(r_q)) ? r_q : out_row_q[2:0];
    lo_row = out_row_q - RowW'(dr);
    cnt    = 4'(hi_row - lo_row + RowW'(1));
    lo_tmp = {1'b0, out_slot_q} - (SlotW+1)'(dr);
    lo_slot = lo_tmp[SlotW] ? SlotW'(lo_tmp + (SlotW+1)'(Rows)) : lo_tmp[SlotW-1:0];
    for (int s = 0; s < Rows; s++) begin
      diff = (SlotW+1)'(s) - {1'b0, lo_slot};
      if (diff[SlotW]) diff = diff + (SlotW+1)'(Rows);
      mask_d[s] = diff < (SlotW+1)'(cnt);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action == dcmf_pkg::ACT_DRAIN) begin
            if (!in_open && (out_row_q < eff_h)) state_d = dcmf_pkg::ST_SETUP;
          end else if (in_open && (n_out != 4'd0)) begin
            state_d = dcmf_pkg::ST_SETUP;
          end
        end
      end
      dcmf_pkg::ST_SETUP: state_d = dcmf_pkg::ST_ISSUE;
      dcmf_pkg::ST_ISSUE: begin
        if (cur_q == chi_q) state_d = dcmf_pkg::ST_WAIT;
      end
      dcmf_pkg::ST_WAIT: begin
        if (tail_i.vld && tail_i.last) state_d = dcmf_pkg::ST_OUT;
      end
      dcmf_pkg::ST_OUT: begin
        if (out_acc) begin
          state_d = (fin || (rem_q == 4'd1)) ? dcmf_pkg::ST_IDLE : dcmf_pkg::ST_SETUP;
        end
      end
      default: state_d = dcmf_pkg::ST_IDLE;
    endcase
  end

  // counters, registers and window datapath
  always_comb begin
    w_raw_d = w_raw_q;
    h_raw_d = h_raw_q;
    r_d = r_q;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    in_slot_d = in_slot_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    out_slot_d = out_slot_q;
    rem_d = rem_q;
    cur_d = cur_q;
    chi_d = chi_q;
    acc_d = acc_q;
    res_d = res_q;
    fold = (tail_i.minv < acc_q) ? tail_i.minv : acc_q;

    if (state_q == dcmf_pkg::ST_IDLE && in_acc) begin
      if (in_data_i.action == dcmf_pkg::ACT_DRAIN) begin
        rem_d = 4'd1;
      end else if (in_open) begin
        rem_d = n_out;
        if (col_end) begin
          in_col_d  = '0;
          in_row_d  = in_row_q + RowW'(1);
          in_slot_d = (in_slot_q == dcmf_pkg::SlotLast) ? '0 : in_slot_q + SlotW'(1);
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
      end
    end

    if (state_q == dcmf_pkg::ST_SETUP) begin
      cur_d = (out_col_q >= ColW'(r_q)) ? out_col_q - ColW'(r_q) : '0;
      chi_d = (c_sum > 11'(wm1)) ? wm1 : c_sum[ColW-1:0];
      acc_d = dcmf_pkg::PixMax;
    end

    if (state_q == dcmf_pkg::ST_ISSUE) begin
      cur_d = cur_q + ColW'(1);
    end

    if (state_q == dcmf_pkg::ST_WAIT && tail_i.vld) begin
      acc_d = fold;
      if (tail_i.last) res_d = fold;
    end

    if (state_q == dcmf_pkg::ST_OUT && out_acc) begin
      rem_d = rem_q - 4'd1;
      if (fin) begin
        in_col_d = '0; in_row_d = '0; in_slot_d = '0;
        out_col_d = '0; out_row_d = '0; out_slot_d = '0;
      end else if (out_col_q == wm1) begin
        out_col_d  = '0;
        out_row_d  = out_row_q + RowW'(1);
        out_slot_d = (out_slot_q == dcmf_pkg::SlotLast) ? '0 : out_slot_q + SlotW'(1);
      end else begin
        out_col_d = out_col_q + ColW'(1);
      end
    end

    // register write restarts the frame
    if (cfg_acc) begin
      unique case (cfg_index_i)
        dcmf_pkg::CFG_WIDTH:  w_raw_d = cfg_data_i[10:0];
        dcmf_pkg::CFG_HEIGHT: h_raw_d = cfg_data_i[RowW-1:0];
        dcmf_pkg::CFG_RADIUS: r_d = cfg_data_i[2:0];
        default: ;
      endcase
      if (cfg_index_i inside {dcmf_pkg::CFG_WIDTH, dcmf_pkg::CFG_HEIGHT,
                              dcmf_pkg::CFG_RADIUS}) begin
        in_col_d = '0; in_row_d = '0; in_slot_d = '0;
        out_col_d = '0; out_row_d = '0; out_slot_d = '0;
      end
    end
  end

  // outputs
  always_comb begin
    in_stall_o  = state_q != dcmf_pkg::ST_IDLE;
    cfg_ready_o = state_q == dcmf_pkg::ST_IDLE;
    out_valid_o = state_q == dcmf_pkg::ST_OUT;
    out_data_o.dark_value = res_q;
    out_data_o.run_last   = (rem_q == 4'd1);
    out_data_o.frame_last = fin;
    wr_o.en   = (state_q == dcmf_pkg::ST_IDLE) && in_acc &&
                (in_data_i.action == dcmf_pkg::ACT_PIXEL) && in_open;
    wr_o.slot = in_slot_q;
    wr_o.addr = in_col_q;
    wr_o.data = pix_min;
    mask_o    = mask_q;
    head_o.vld  = state_q == dcmf_pkg::ST_ISSUE;
    head_o.last = cur_q == chi_q;
    head_o.addr = cur_q;
    head_o.minv = dcmf_pkg::PixMax;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcmf_pkg::ST_IDLE;
      w_raw_q <= 11'd640;
      h_raw_q <= RowW'(480);
      r_q <= 3'd7;
      in_col_q <= '0;
      in_row_q <= '0;
      in_slot_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_slot_q <= '0;
      rem_q <= '0;
    end else begin
      state_q <= state_d;
      w_raw_q <= w_raw_d;
      h_raw_q <= h_raw_d;
      r_q <= r_d;
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      in_slot_q <= in_slot_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      out_slot_q <= out_slot_d;
      rem_q <= rem_d;
    end
  end

  // window payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    chi_q <= chi_d;
    acc_q <= acc_d;
    res_q <= res_d;
    if (state_q == dcmf_pkg::ST_SETUP) mask_q <= mask_d;
  end

endmodule
`default_nettype wire

@@ rtl/dark_channel_min_filter_core.sv @@
// top level of the dark channel minimum filter
`default_nettype none
// Streaming dark channel filter: pixels arrive in raster order, the minimum of
// blue, green and red is stored in a 15-row line store, and each result is the
// minimum over a (2R+1) square window with replicated borders. Items are taken
// one at a time. Each result passes a setup state, an issue state that sends one
// column request per window column (up to 2R+1, fewer at the left and right
// borders), a wait state while the requests pass the chain of 15 row cells (two
// register stages each, one per line store row) and the output state; a row end
// pixel emits up to R+1 such results back to back. Output stalls hold the result
// in the output state. Drain items emit the pending results of the last R rows,
// one each. Register writes are taken while no item is in progress and restart
// the frame.
module dark_channel_min_filter_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire dcmf_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output dcmf_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [dcmf_pkg::CfgW-1:0] cfg_data_i
);

  localparam int Rows  = dcmf_pkg::StoreRows;
  localparam int SlotW = dcmf_pkg::SlotW;

  dcmf_pkg::wr_t   wr;
  logic [Rows-1:0] mask;
  dcmf_pkg::link_t chain [Rows+1];

  // sequencing and counters
  dcmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_o        (wr),
    .mask_o      (mask),
    .head_o      (chain[0]),
    .tail_i      (chain[Rows])
  );

  // one cell per line store row
  for (genvar k = 0; k < Rows; k++) begin : g_cell
    dcmf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr.en && (wr.slot == SlotW'(k))),
      .wr_addr_i (wr.addr),
      .wr_data_i (wr.data),
      .incl_i    (mask[k]),
      .link_i    (chain[k]),
      .link_o    (chain[k+1])
    );
  end

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// self-checking testbench of the dark channel minimum filter core
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;
  localparam int SettleCycles = 60;
  localparam int ItemTarget = 320;
  localparam int CutLimit = 40;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [dcmf_pkg::CfgW-1:0] cfg_data_i;
  dcmf_pkg::in_t in_data_i;
  dcmf_pkg::out_t out_data_o;

  dark_channel_min_filter_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o,
    .out_stall_i, .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // predicted state of the filter
  logic [7:0] min_store [dcmf_pkg::StoreRows][dcmf_pkg::MaxWidth];
  logic [10:0] reg_width;
  logic [11:0] reg_height;
  logic [2:0] reg_radius;
  int unsigned px_col, px_row, dk_col, dk_row;
  dcmf_pkg::out_t dark_q [$];

  int errors;
  int send_pct, stall_pct;
  int hold_left;
  int items_sent;

  function automatic int unsigned frame_w();
    if (reg_width == 0) return 1;
    if (reg_width > dcmf_pkg::MaxWidth) return dcmf_pkg::MaxWidth;
    return 32'(reg_width);
  endfunction

  function automatic int unsigned frame_h();
    return (reg_height == 0) ? 1 : 32'(reg_height);
  endfunction

  function automatic logic [7:0] window_floor(int r, int c);
    int w, h, rad, rr, cc;
    logic [7:0] m;
    w = frame_w();
    h = frame_h();
    rad = int'(reg_radius);
    m = dcmf_pkg::PixMax;
    for (int dr = -rad; dr <= rad; dr++) begin
      rr = r + dr;
      if (rr < 0) rr = 0;
      if (rr > h - 1) rr = h - 1;
      for (int dc = -rad; dc <= rad; dc++) begin
        cc = c + dc;
        if (cc < 0) cc = 0;
        if (cc > w - 1) cc = w - 1;
        if (min_store[rr % dcmf_pkg::StoreRows][cc] < m) begin
          m = min_store[rr % dcmf_pkg::StoreRows][cc];
        end
      end
    end
    return m;
  endfunction

  // next output position, returns 1 when it closes the frame
  function automatic bit push_dark(bit last_of_run);
    dcmf_pkg::out_t o;
    bit fin;
    fin = (dk_row == frame_h() - 1) && (dk_col == frame_w() - 1);
    o.dark_value = window_floor(dk_row, dk_col);
    o.run_last = last_of_run;
    o.frame_last = fin;
    dark_q.push_back(o);
    dk_col++;
    if (dk_col >= frame_w()) begin
      dk_col = 0;
      dk_row++;
    end
    return fin;
  endfunction

  function automatic void restart_frame();
    px_col = 0; px_row = 0; dk_col = 0; dk_row = 0;
  endfunction

  function automatic void predict_word(dcmf_pkg::in_t d);
    int unsigned w, h, rad, n;
    logic [7:0] m;
    w = frame_w();
    h = frame_h();
    rad = 32'(reg_radius);
    n = 0;
    if (d.action == dcmf_pkg::ACT_DRAIN) begin
      if (px_row < h || dk_row >= h) return;
      if (push_dark(1'b1)) restart_frame();
      return;
    end
    if (px_row >= h) return;
    m = d.blue;
    if (d.green < m) m = d.green;
    if (d.red < m) m = d.red;
    min_store[px_row % dcmf_pkg::StoreRows][px_col] = m;
    if (px_row >= rad) begin
      if (px_col < w - 1) n = (px_col >= rad) ? 1 : 0;
      else n = (w < rad + 1) ? w : rad + 1;
    end
    px_col++;
    if (px_col >= w) begin
      px_col = 0;
      px_row++;
    end
    for (int k = 0; k < n; k++) begin
      if (push_dark(k == n - 1)) begin
        restart_frame();
        return;
      end
    end
  endfunction

  // send one word, keeping valid high across back-to-back words
  task automatic send_word(dcmf_pkg::in_t d);
    if ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(d);
    items_sent++;
  endtask

  task automatic end_words();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    end_words();
    while (dark_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(dcmf_pkg::cfg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= dcmf_pkg::CfgW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      dcmf_pkg::CFG_WIDTH: reg_width = 11'(val);
      dcmf_pkg::CFG_HEIGHT: reg_height = 12'(val);
      default: reg_radius = 3'(val);
    endcase
    restart_frame();
  endtask

  function automatic dcmf_pkg::in_t rand_pixel();
    dcmf_pkg::in_t d;
    d.action = dcmf_pkg::ACT_PIXEL;
    d.blue = 8'($urandom_range(255));
    d.green = 8'($urandom_range(255));
    d.red = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) d.red = 8'd0;
    if ($urandom_range(9) == 0) d.blue = dcmf_pkg::PixMax;
    return d;
  endfunction

  // one frame with random pixels; noise words and early abandon mixed in
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned r, bit cut_short);
    int unsigned total;
    dcmf_pkg::in_t drain;
    drain = '0;
    drain.action = dcmf_pkg::ACT_DRAIN;
    wait_idle();
    write_reg(dcmf_pkg::CFG_RADIUS, r);
    write_reg(dcmf_pkg::CFG_HEIGHT, h);
    write_reg(dcmf_pkg::CFG_WIDTH, w);
    total = frame_w() * frame_h();
    if (cut_short) total = $urandom_range(1, (total < CutLimit) ? total : CutLimit);
    for (int unsigned p = 0; p < total; p++) begin
      if (p + 1 < total && $urandom_range(19) == 0) send_word(drain);
      send_word(rand_pixel());
    end
    if (cut_short) return;
    if ($urandom_range(4) == 0) send_word(rand_pixel());
    while (px_row >= frame_h() && dk_row < frame_h()) send_word(drain);
    if ($urandom_range(4) == 0) send_word(drain);
  endtask

  // directed rows
  typedef struct {
    bit is_reg;
    dcmf_pkg::cfg_idx_e idx;
    int unsigned val;
    dcmf_pkg::in_t word;
    bit typed;
    logic [7:0] dark;
  } dir_row_t;

  localparam dcmf_pkg::in_t Drain = '{action: 1'b1, default: '0};

  dir_row_t dir_tab [26] = '{
    '{1'b1, dcmf_pkg::CFG_WIDTH, 1, '0, 1'b0, 8'd0},
    '{1'b1, dcmf_pkg::CFG_HEIGHT, 1, '0, 1'b0, 8'd0},
    '{1'b1, dcmf_pkg::CFG_RADIUS, 0, '0, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd0, 8'd255, 8'd255}, 1'b1, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd255, 8'd255, 8'd255}, 1'b1, 8'd255},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd255, 8'd7, 8'd255}, 1'b1, 8'd7},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd255, 8'd255, 8'd3}, 1'b1, 8'd3},
    '{1'b1, dcmf_pkg::CFG_HEIGHT, 0, '0, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd9, 8'd9, 8'd9}, 1'b1, 8'd9},
    '{1'b1, dcmf_pkg::CFG_WIDTH, 0, '0, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd200, 8'd100, 8'd50}, 1'b1, 8'd50},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, Drain, 1'b0, 8'd0},
    '{1'b1, dcmf_pkg::CFG_WIDTH, 3, '0, 1'b0, 8'd0},
    '{1'b1, dcmf_pkg::CFG_HEIGHT, 2, '0, 1'b0, 8'd0},
    '{1'b1, dcmf_pkg::CFG_RADIUS, 1, '0, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd40, 8'd90, 8'd60}, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd170, 8'd85, 8'd200}, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd30, 8'd31, 8'd32}, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, Drain, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd120, 8'd240, 8'd15}, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd99, 8'd1, 8'd77}, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd66, 8'd55, 8'd44}, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, '{1'b0, 8'd0, 8'd0, 8'd0}, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, Drain, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, Drain, 1'b0, 8'd0},
    '{1'b0, dcmf_pkg::CFG_WIDTH, 0, Drain, 1'b0, 8'd0}
  };

  // result check and receiver stalls
  always @(posedge clk_i) begin
    dcmf_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dark_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_data_o);
        errors++;
      end else begin
        want = dark_q.pop_front();
        if (out_data_o.dark_value !== want.dark_value) begin
          $error("dark_value expected %0d got %0d", want.dark_value, out_data_o.dark_value);
          errors++;
        end
        if (out_data_o.run_last !== want.run_last) begin
          $error("run_last expected %0d got %0d", want.run_last, out_data_o.run_last);
          errors++;
        end
        if (out_data_o.frame_last !== want.frame_last) begin
          $error("frame_last expected %0d got %0d", want.frame_last, out_data_o.frame_last);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("dark_channel_min_filter_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    int frame_no;
    int unsigned w, h;
    errors = 0;
    send_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    items_sent = 0;
    quiet_cycles = 0;
    reg_width = 11'd640;
    reg_height = 12'd480;
    reg_radius = 3'd7;
    restart_frame();
    for (int i = 0; i < dcmf_pkg::StoreRows; i++)
      for (int j = 0; j < dcmf_pkg::MaxWidth; j++) min_store[i][j] = '0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= dcmf_pkg::CFG_WIDTH;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].word);
        if (dir_tab[i].typed) begin
          if (dark_q.size() == 0) begin
            $error("dark_value expected %0d got no result", dir_tab[i].dark);
            errors++;
          end else if (dark_q[$].dark_value !== dir_tab[i].dark) begin
            $error("dark_value expected %0d got %0d", dir_tab[i].dark,
                   dark_q[$].dark_value);
            errors++;
          end
        end
      end
    end

    // widest setting clamps to the line length, first part of the row
    run_frame(2047, 1, 0, 1'b1);
    // tallest frame, abandoned within its first ten rows
    run_frame(4, 4095, 7, 1'b1);

    // random frames across idling phases
    frame_no = 0;
    while (items_sent < ItemTarget) begin
      case (frame_no % 4)
        0: begin send_pct = 0; stall_pct = 0; end
        1: begin send_pct = 61; stall_pct = 0; end
        2: begin send_pct = 0; stall_pct = 61; end
        default: begin send_pct = 35; stall_pct = 35; end
      endcase
      w = ($urandom_range(7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
      h = $urandom_range(1, (w > 10) ? 3 : 9);
      if (frame_no == 4) begin
        send_pct = 0;
        hold_left = 400;
      end
      run_frame(w, h, $urandom_range(7), $urandom_range(9) == 0);
      frame_no++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("dark_channel_min_filter_core test passed");
    end else begin
      $display("dark_channel_min_filter_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ dark_channel_min_filter_core.f @@
rtl/dcmf_pkg.sv
rtl/dcmf_cell.sv
rtl/dcmf_ctrl.sv
rtl/dark_channel_min_filter_core.sv
bench/testbench.sv
